@@ src/ps2mct_pkg.sv @@
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared constants and types for the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  // Cursor coordinate width
  localparam int COORD_BITS = 13;
  // Width of the screen extent registers
  localparam int CFG_BITS   = 14;
  // Signed width for position arithmetic: covers extent, coordinate and delta
  localparam int POS_BITS   = ((CFG_BITS > COORD_BITS) ? CFG_BITS : COORD_BITS) + 3;
  // Signed movement range is -510..+510
  localparam int DELTA_BITS = 10;

  // Result payload layout
  localparam int RES_BITS   = 2 * COORD_BITS + 3;
  localparam int TDATA_BITS = ((RES_BITS + 7) / 8) * 8;

  // Register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET  = CFG_BITS'(1024);
  localparam logic [CFG_BITS-1:0] HEIGHT_RESET = CFG_BITS'(768);

  // Header bit positions
  localparam int HDR_LEFT   = 0;
  localparam int HDR_RIGHT  = 1;
  localparam int HDR_MIDDLE = 2;
  localparam int HDR_SYNC   = 3;
  localparam int HDR_XSIGN  = 4;
  localparam int HDR_YSIGN  = 5;
  localparam int HDR_XOVF   = 6;
  localparam int HDR_YOVF   = 7;

  // Packet byte position
  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_X    = 2'd1,
    PH_Y    = 2'd2,
    PH_BAD  = 2'd3
  } phase_t;

  // One cursor result
  typedef struct packed {
    logic                  middle_button;
    logic                  right_button;
    logic                  left_button;
    logic [COORD_BITS-1:0] cursor_y;
    logic [COORD_BITS-1:0] cursor_x;
  } result_t;

endpackage

@@ src/ps2mct_axis.sv @@
// ----------------------------------------------------------------------------
// ps2mct_axis
// Applies one axis movement byte to a coordinate and clamps it to the screen.
// ----------------------------------------------------------------------------
module ps2mct_axis
  import ps2mct_pkg::*;
(
  input  logic [COORD_BITS-1:0] cur,
  input  logic [7:0]            raw,
  input  logic                  neg,
  input  logic                  ovf,
  input  logic                  invert,
  input  logic [CFG_BITS-1:0]   extent,
  output logic [COORD_BITS-1:0] nxt
);

  logic signed [DELTA_BITS-1:0] base;
  logic signed [DELTA_BITS-1:0] delta;
  logic signed [POS_BITS-1:0]   delta_ext;
  logic signed [POS_BITS-1:0]   cur_ext;
  logic signed [POS_BITS-1:0]   pos;
  logic [CFG_BITS-1:0]          lim_raw;
  logic [POS_BITS-1:0]          lim;
  logic [POS_BITS-1:0]          mask;

  // Decode signed movement; a set sign bit with a zero byte and no overflow moves by zero
  always_comb begin
    if (!neg) begin
      base  = signed'(DELTA_BITS'(raw));
      delta = ovf ? base + DELTA_BITS'(255) : base;
    end else begin
      base  = (raw == 8'd0) ? '0 : signed'(DELTA_BITS'(raw)) - DELTA_BITS'(256);
      delta = ovf ? base - DELTA_BITS'(255) : base;
    end
  end

  // Add or subtract the movement
  assign delta_ext = {{(POS_BITS-DELTA_BITS){delta[DELTA_BITS-1]}}, delta};
  assign cur_ext   = signed'(POS_BITS'(cur));
  assign pos       = invert ? cur_ext - delta_ext : cur_ext + delta_ext;

  // Clamp limit: extent minus one, zero extent treated as one, capped at range
  assign lim_raw = (extent == '0) ? '0 : extent - CFG_BITS'(1);
  assign mask    = POS_BITS'({COORD_BITS{1'b1}});
  assign lim     = (POS_BITS'(lim_raw) > mask) ? mask : POS_BITS'(lim_raw);

  always_comb begin
    if (pos[POS_BITS-1]) begin
      nxt = '0;
    end else if (unsigned'(pos) > lim) begin
      nxt = lim[COORD_BITS-1:0];
    end else begin
      nxt = pos[COORD_BITS-1:0];
    end
  end

endmodule

@@ src/ps2mct_out_reg.sv @@
// ----------------------------------------------------------------------------
// ps2mct_out_reg
// Result register on the master side; frees itself as its transaction ends.
// ----------------------------------------------------------------------------
module ps2mct_out_reg
  import ps2mct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  result_t               res,
  output logic                  free,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [TDATA_BITS-1:0] m_tdata
);

  result_t held;

  assign free = !m_tvalid || m_tready;

  // Hold valid until the transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (free) begin
      m_tvalid <= load;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (free && load) begin
      held <= res;
    end
  end

  assign m_tdata = TDATA_BITS'(held);

endmodule

@@ src/ps2_mouse_packet_cursor_tracker.sv @@
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker
// Collects three-byte PS/2 mouse packets and tracks a clamped cursor.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// s_*       in   tdata[7:0] rx_byte
// m_*       out  tdata: cursor_x, cursor_y, left, right, middle (low bit up)
// cfg_*     in   index 0 screen_width, index 1 screen_height
//
// One byte is accepted per cycle except while a packet's last byte waits. A
// byte is registered, then decoded in the next cycle; the third byte of a
// packet loads the result register from there. Only a byte that completes a
// packet waits on a full result register. Reset (synchronous) empties both
// registers, restarts packet framing and sets the cursor to the origin.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker
  import ps2mct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] rx_byte
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [12:0] cursor_x, [25:13] cursor_y, [26] left_button, [27] right_button,
  // [28] middle_button, rest zero
  output logic [TDATA_BITS-1:0] m_tdata
);

  logic [CFG_BITS-1:0]   screen_width;
  logic [CFG_BITS-1:0]   screen_height;
  logic                  in_valid;
  logic [7:0]            in_byte;
  phase_t                phase;
  phase_t                phase_next;
  logic [7:0]            header_byte;
  logic [7:0]            x_delta_byte;
  logic [COORD_BITS-1:0] cursor_col;
  logic [COORD_BITS-1:0] cursor_row;
  logic [COORD_BITS-1:0] col_next;
  logic [COORD_BITS-1:0] row_next;
  logic                  take_header;
  logic                  take_x;
  logic                  emit;
  logic                  out_free;
  logic                  advance;
  result_t               res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  screen_width  <= cfg_wdata;
        REG_HEIGHT: screen_height <= cfg_wdata;
        default:    ;
      endcase
    end
  end

  // Input register
  assign advance  = in_valid && (!emit || out_free);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_byte <= s_tdata;
    end
  end

  // Next packet position
  always_comb begin
    unique case (phase)
      PH_HEAD: phase_next = in_byte[HDR_SYNC] ? PH_X : PH_HEAD;
      PH_X:    phase_next = PH_Y;
      PH_Y:    phase_next = PH_HEAD;
      default: phase_next = PH_HEAD;
    endcase
  end

  // Per-position actions
  always_comb begin
    take_header = 1'b0;
    take_x      = 1'b0;
    emit        = 1'b0;
    unique case (phase)
      PH_HEAD: take_header = in_valid && in_byte[HDR_SYNC];
      PH_X:    take_x      = in_valid;
      PH_Y:    emit        = in_valid;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEAD;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

  // Hold packet bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte  <= '0;
      x_delta_byte <= '0;
    end else if (advance) begin
      if (take_header) begin
        header_byte <= in_byte;
      end
      if (take_x) begin
        x_delta_byte <= in_byte;
      end
    end
  end

  // Axis updates
  ps2mct_axis u_axis_x (
    .cur    (cursor_col),
    .raw    (x_delta_byte),
    .neg    (header_byte[HDR_XSIGN]),
    .ovf    (header_byte[HDR_XOVF]),
    .invert (1'b0),
    .extent (screen_width),
    .nxt    (col_next)
  );

  ps2mct_axis u_axis_y (
    .cur    (cursor_row),
    .raw    (in_byte),
    .neg    (header_byte[HDR_YSIGN]),
    .ovf    (header_byte[HDR_YOVF]),
    .invert (1'b1),
    .extent (screen_height),
    .nxt    (row_next)
  );

  // Advance the kept cursor on a finished packet
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (advance && emit) begin
      cursor_col <= col_next;
      cursor_row <= row_next;
    end
  end

  assign res.cursor_x      = col_next;
  assign res.cursor_y      = row_next;
  assign res.left_button   = header_byte[HDR_LEFT];
  assign res.right_button  = header_byte[HDR_RIGHT];
  assign res.middle_button = header_byte[HDR_MIDDLE];

  ps2mct_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && emit),
    .res      (res),
    .free     (out_free),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

@@ sim/cursor_track_check.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cursor_track_check
// Watches the byte, result and register channels of the cursor tracker,
// rebuilds the packet framing and cursor on its own, and compares every
// cursor update against the oldest one it predicted.
// ----------------------------------------------------------------------------
module cursor_track_check
  import ps2mct_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_wdata,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] rx_byte
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  // [12:0] cursor_x, [25:13] cursor_y, [26] left_button, [27] right_button,
  // [28] middle_button, rest zero
  input  logic [TDATA_BITS-1:0] m_tdata,
  output int                    mismatches,
  output int                    outstanding,
  output int                    updates_checked
);

  // Predicted screen extent and packet framing
  logic [CFG_BITS-1:0]   scr_w;
  logic [CFG_BITS-1:0]   scr_h;
  phase_t                byte_pos;
  logic [7:0]            head_q;
  logic [7:0]            xmove_q;
  logic [COORD_BITS-1:0] col;
  logic [COORD_BITS-1:0] row;
  result_t               pending_moves[$];

  // Signed movement of one axis from its raw byte and the header sign/overflow
  function automatic int axis_move(logic [7:0] raw, logic neg, logic ovf);
    logic [7:0] mag;
    int         d;
    if (!neg) begin
      d = int'(raw);
      if (ovf) d = d + 255;
    end else begin
      mag = 8'd0 - raw;
      d = -int'(mag);
      if (ovf) d = d - 255;
    end
    return d;
  endfunction

  // Clamp a position to [0, extent-1], a zero extent acting as one
  function automatic logic [COORD_BITS-1:0] clamp_coord(int pos, logic [CFG_BITS-1:0] extent);
    int lim;
    lim = (extent == '0) ? 0 : int'(extent) - 1;
    if (lim > (1 << COORD_BITS) - 1) lim = (1 << COORD_BITS) - 1;
    if (pos < 0) return '0;
    if (pos > lim) return COORD_BITS'(lim);
    return COORD_BITS'(pos);
  endfunction

  // Report one bad result, only the first few in full
  task automatic note_mismatch(input string what, input result_t want, input result_t got);
    if (mismatches < 10) begin
      $display("%0t cursor_track_check: %s: expected x=%0d y=%0d lrm=%b%b%b",
               $realtime, what, want.cursor_x, want.cursor_y, want.left_button,
               want.right_button, want.middle_button);
      $display("    got x=%0d y=%0d lrm=%b%b%b pad=%h",
               got.cursor_x, got.cursor_y, got.left_button, got.right_button,
               got.middle_button, m_tdata[TDATA_BITS-1:RES_BITS]);
    end
    mismatches <= mismatches + 1;
  endtask

  // Compare results, track register writes and predict from accepted bytes
  always @(posedge clk) begin : track
    result_t want;
    result_t got;
    int      nx;
    int      ny;
    if (rst) begin
      scr_w = WIDTH_RESET;
      scr_h = HEIGHT_RESET;
      byte_pos = PH_HEAD;
      head_q = '0;
      xmove_q = '0;
      col = '0;
      row = '0;
      pending_moves.delete();
      mismatches <= 0;
      updates_checked <= 0;
    end else begin
      // Check the result leaving this edge against the oldest prediction
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[RES_BITS-1:0]);
        if (pending_moves.size() == 0) begin
          want = '0;
          note_mismatch("result with none expected", want, got);
        end else begin
          want = pending_moves.pop_front();
          if (got.cursor_x !== want.cursor_x || got.cursor_y !== want.cursor_y ||
              got.left_button !== want.left_button ||
              got.right_button !== want.right_button ||
              got.middle_button !== want.middle_button ||
              m_tdata[TDATA_BITS-1:RES_BITS] !== '0)
            note_mismatch("cursor update differs", want, got);
          updates_checked <= updates_checked + 1;
        end
      end

      // Register write
      if (cfg_we) begin
        if (cfg_index == REG_WIDTH) scr_w = cfg_wdata;
        else scr_h = cfg_wdata;
      end

      // Advance packet framing on an accepted byte
      if (s_tvalid && s_tready) begin
        case (byte_pos)
          PH_HEAD: begin
            if (s_tdata[HDR_SYNC]) begin
              head_q = s_tdata;
              byte_pos = PH_X;
            end
          end
          PH_X: begin
            xmove_q = s_tdata;
            byte_pos = PH_Y;
          end
          PH_Y: begin
            byte_pos = PH_HEAD;
            nx = int'(col) + axis_move(xmove_q, head_q[HDR_XSIGN], head_q[HDR_XOVF]);
            ny = int'(row) - axis_move(s_tdata, head_q[HDR_YSIGN], head_q[HDR_YOVF]);
            col = clamp_coord(nx, scr_w);
            row = clamp_coord(ny, scr_h);
            want.cursor_x = col;
            want.cursor_y = row;
            want.left_button = head_q[HDR_LEFT];
            want.right_button = head_q[HDR_RIGHT];
            want.middle_button = head_q[HDR_MIDDLE];
            pending_moves.push_back(want);
          end
          default: byte_pos = PH_HEAD;
        endcase
      end
    end
    outstanding <= pending_moves.size();
  end

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives PS/2 mouse bytes into the cursor tracker: a short directed packet
// set, then random packets with noise and broken packets under a range of
// screen sizes, with bursty input and a stalling result receiver. A checker
// beside the block predicts and compares every cursor update.
// ----------------------------------------------------------------------------
module tb;
  import ps2mct_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_BYTES   = 90;
  localparam int NUM_SETTINGS  = 7;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic                  cfg_index = REG_WIDTH;
  logic [CFG_BITS-1:0]   cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;    // [7:0] rx_byte
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [12:0] cursor_x, [25:13] cursor_y, [26] left_button, [27] right_button,
  // [28] middle_button, rest zero
  logic [TDATA_BITS-1:0] m_tdata;

  int mismatches;
  int outstanding;
  int updates_checked;

  // Sender bookkeeping
  int burst_left    = 0;
  int frame_pos     = 0;
  int bytes_counted = 0;
  int bytes_dropped = 0;
  int settings_used = 0;
  int bias_x        = 0;
  int bias_y        = 0;

  // Receiver stall pattern state
  int         stall_mode = 0;
  int         mode_left  = 0;
  logic [7:0] ready_pat  = 8'hA5;

  int idle_run = 0;

  ps2_mouse_packet_cursor_tracker uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  cursor_track_check checker_i (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .updates_checked (updates_checked)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: switch between always ready, random, rotating pattern and long stalls
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      mode_left <= $urandom_range(32, 200);
      ready_pat <= 8'($urandom_range(1, 255));
    end else begin
      mode_left <= mode_left - 1;
      ready_pat <= {ready_pat[6:0], ready_pat[7]};
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ready_pat[0];
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // Watchdog: end the run after too long without any transaction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      idle_run <= 0;
    end else if (idle_run >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  // Send one byte, opening a new burst after a random gap when due
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left = burst_left - 1;
    // Follow the framing so well-formed packets can start on a header slot
    if (frame_pos == 0) begin
      if (b[HDR_SYNC]) begin
        frame_pos = 1;
        bytes_counted = bytes_counted + 1;
      end else begin
        bytes_dropped = bytes_dropped + 1;
      end
    end else begin
      frame_pos = (frame_pos + 1) % 3;
      bytes_counted = bytes_counted + 1;
    end
  endtask

  // Hold the input, then wait until every expected update is out and the pipe settles
  task automatic drain;
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both screen extent registers, width first and then height
  task automatic set_screen(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
    cfg_we <= 1'b1;
    cfg_index <= REG_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used = settings_used + 1;
  endtask

  // Random packet, leaning toward the current drift so the cursor reaches the edges
  task automatic send_packet;
    logic [7:0] hdr;
    while (frame_pos != 0) send_byte(8'($urandom));
    hdr = 8'($urandom);
    hdr[HDR_SYNC] = 1'b1;
    if (bias_x != 0 && $urandom_range(0, 3) != 0) begin
      hdr[HDR_XSIGN] = (bias_x < 0);
      hdr[HDR_XOVF] = 1'($urandom_range(0, 1));
    end
    // Y is inverted: a negative delta moves the cursor down
    if (bias_y != 0 && $urandom_range(0, 3) != 0) begin
      hdr[HDR_YSIGN] = (bias_y > 0);
      hdr[HDR_YOVF] = 1'($urandom_range(0, 1));
    end
    send_byte(hdr);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
  endtask

  // Noise: a stray non-header byte, a truncated packet, or any byte at all
  task automatic send_noise;
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0: begin
        b = 8'($urandom);
        b[HDR_SYNC] = 1'b0;
        send_byte(b);
      end
      1: begin
        b = 8'($urandom);
        b[HDR_SYNC] = 1'b1;
        send_byte(b);
        if ($urandom_range(0, 1) != 0) send_byte(8'($urandom));
      end
      default: send_byte(8'($urandom));
    endcase
  endtask

  task automatic pick_drift;
    bias_x = $urandom_range(0, 2) - 1;
    bias_y = $urandom_range(0, 2) - 1;
  endtask

  initial begin : stimulus
    logic [7:0]          opening_bytes [23];
    logic [CFG_BITS-1:0] widths [NUM_SETTINGS];
    logic [CFG_BITS-1:0] heights [NUM_SETTINGS];
    int                  phase_start;

    // Dropped non-headers, then packets over every sign/overflow corner and button
    opening_bytes = '{8'h00, 8'hF7,
                      8'h09, 8'h7F, 8'h00,
                      8'h0A, 8'h80, 8'h7F,
                      8'hFF, 8'h01, 8'h01,
                      8'hCF, 8'hFF, 8'h00,
                      8'h3C, 8'h00, 8'h80,
                      8'h48, 8'hFF, 8'hFF,
                      8'h88, 8'h00, 8'h00};
    // Screen settings: oversize, full range, zero, one, random, odd shapes, reset values
    widths  = '{14'd16383, 14'd8192, 14'd0, 14'd1, 14'($urandom_range(2, 8191)),
                14'd8193, 14'd1024};
    heights = '{14'd16383, 14'd8192, 14'd0, 14'd1, 14'($urandom_range(2, 8191)),
                14'd2, 14'd768};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at reset screen size
    foreach (opening_bytes[i]) send_byte(opening_bytes[i]);

    // Random part: reset screen size first, then each setting in turn
    for (int p = -1; p < NUM_SETTINGS; p++) begin
      if (p >= 0) begin
        drain();
        set_screen(widths[p], heights[p]);
      end
      // Push hard toward the far corner on the first, oversize screen
      if (p == 0) begin
        bias_x = 1;
        bias_y = 1;
      end else begin
        pick_drift();
      end
      phase_start = bytes_counted;
      while (bytes_counted - phase_start < PHASE_BYTES) begin
        if ($urandom_range(0, 99) < 15) send_noise();
        else send_packet();
        if (p != 0 && $urandom_range(0, 15) == 0) pick_drift();
      end
    end

    // Flush and let any last result leave
    drain();
    repeat (10) @(posedge clk);

    $display("tb: %0d bytes framed, %0d non-header bytes dropped, %0d screen settings written",
             bytes_counted, bytes_dropped, settings_used);
    $display("tb: %0d cursor updates compared, %0d mismatches", updates_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
